### hdl/efr_pkg.sv
package efr_pkg;

  // receive phases
  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_PAYLOAD = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BADHDR  = 3'd2,
    ST_BADESC  = 3'd3,
    ST_BADCHK  = 3'd4,
    ST_TOOLONG = 3'd5
  } status_e;

  // register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MAX_LENGTH    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0]  HeaderFirstRst  = 8'hAA;
  localparam logic [7:0]  HeaderSecondRst = 8'h55;
  localparam logic [15:0] MaxLengthRst    = 16'hFFFF;

  // one result word
  typedef struct packed {
    status_e     status;
    logic [7:0]  payload_byte;
    logic [15:0] position;
  } result_t;

endpackage

### hdl/escaped_frame_receiver.sv
// Channel   Dir  Handshake                     Word
// --------  ---  ----------------------------  ---------------------------------
// in        in   in_valid_i / in_stall_o       rx_byte_i
// out       out  out_valid_o / out_stall_i     status_o, payload_byte_o, position_o
// cfg       in   APB psel/penable/pwrite       paddr, pwdata -> prdata, pready
//
// One byte per cycle sustained while the output is not stalled; a byte's result
// (if any) is registered: the byte is held in the input register while
// the deframer logic computes its result into the output register.
// Reset (rst_ni low, async) returns to hunting for the first header byte and
// restores the register defaults. A stall on the output holds the result
// register and, once the input register is full too, stalls the input.
module escaped_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input bytes
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [7:0]                     payload_byte_o,
  output logic [15:0]                    position_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efr_pkg::AddrWidth-1:0]  paddr,
  input  logic [efr_pkg::DataWidth-1:0]  pwdata,
  output logic [efr_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);

  import efr_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [15:0] max_len_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
      max_len_q    <= MaxLengthRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEADER_FIRST:  hdr_first_q  <= pwdata[7:0];
        REG_HEADER_SECOND: hdr_second_q <= pwdata[7:0];
        REG_MAX_LENGTH:    max_len_q    <= pwdata[15:0];
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_HEADER_FIRST:  prdata = {{(DataWidth-8){1'b0}}, hdr_first_q};
      REG_HEADER_SECOND: prdata = {{(DataWidth-8){1'b0}}, hdr_second_q};
      REG_MAX_LENGTH:    prdata = {{(DataWidth-16){1'b0}}, max_len_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_fire;
  logic       adv;  // input word moves through the deframer this cycle

  logic       out_vld_q, out_vld_d;
  result_t    out_q;

  // result register free, or being emptied this cycle
  assign adv        = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~adv;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign in_vld_d   = in_fire | (in_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Deframer state
  // ---------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [7:0]  chk_q, chk_d;

  logic        emit;
  result_t     res;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] bcnt_inc;

  assign b        = in_byte_q;
  assign len_full = {b, flen_q[7:0]};
  assign bcnt_inc = bcnt_q + 16'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    flen_d  = flen_q;
    bcnt_d  = bcnt_q;
    chk_d   = chk_q;
    unique case (phase_q)
      PH_HUNT1: begin
        if (b == hdr_first_q) phase_d = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == hdr_second_q) begin
          phase_d = PH_LEN_LO;
          esc_d   = 1'b0;
          flen_d  = '0;
          bcnt_d  = '0;
          chk_d   = '0;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CHECK: begin
        if (esc_q && b != hdr_first_q) begin
          // broken stuffing: drop the byte and resync
          esc_d   = 1'b0;
          phase_d = PH_HUNT1;
        end else if (!esc_q && b == hdr_first_q) begin
          esc_d = 1'b1;  // wait for its double
        end else begin
          esc_d = 1'b0;
          unique case (phase_q)
            PH_LEN_LO: begin
              flen_d  = {8'h00, b};
              chk_d   = b;
              phase_d = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              flen_d = len_full;
              chk_d  = chk_q ^ b;
              bcnt_d = '0;
              if (len_full > max_len_q)  phase_d = PH_HUNT1;
              else if (len_full == '0)   phase_d = PH_CHECK;
              else                       phase_d = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              chk_d  = chk_q ^ b;
              bcnt_d = bcnt_inc;
              if (bcnt_inc == flen_q) phase_d = PH_CHECK;
            end
            default: phase_d = PH_HUNT1;  // check byte ends the frame
          endcase
        end
      end
      default: begin
        phase_d = PH_HUNT1;
        esc_d   = 1'b0;
      end
    endcase
  end

  // result word
  always_comb begin
    emit             = 1'b0;
    res.status       = ST_PAYLOAD;
    res.payload_byte = '0;
    res.position     = '0;
    unique case (phase_q)
      PH_HUNT2: begin
        if (b != hdr_second_q) begin
          emit       = 1'b1;
          res.status = ST_BADHDR;
        end
      end
      PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CHECK: begin
        if (esc_q && b != hdr_first_q) begin
          emit         = 1'b1;
          res.status   = ST_BADESC;
          res.position = (phase_q == PH_PAYLOAD || phase_q == PH_CHECK) ? flen_q : '0;
        end else if (esc_q || b != hdr_first_q) begin
          unique case (phase_q)
            PH_LEN_HI: begin
              if (len_full > max_len_q) begin
                emit         = 1'b1;
                res.status   = ST_TOOLONG;
                res.position = len_full;
              end
            end
            PH_PAYLOAD: begin
              emit             = 1'b1;
              res.status       = ST_PAYLOAD;
              res.payload_byte = b;
              res.position     = bcnt_q;
            end
            PH_CHECK: begin
              emit         = 1'b1;
              res.status   = (b == chk_q) ? ST_GOOD : ST_BADCHK;
              res.position = flen_q;
            end
            default: ;  // low length byte: nothing out
          endcase
        end
      end
      default: ;  // hunting: noise gives no result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      esc_q   <= 1'b0;
      flen_q  <= '0;
      bcnt_q  <= '0;
      chk_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      flen_q  <= flen_d;
      bcnt_q  <= bcnt_d;
      chk_q   <= chk_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (adv)               out_vld_d = emit;
    else if (!out_stall_i) out_vld_d = 1'b0;
    else                   out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_q.status;
  assign payload_byte_o = out_q.payload_byte;
  assign position_o     = out_q.position;

`ifndef NO_ASSERTIONS
  // escape state never survives outside the stuffed fields
  a_no_esc_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT1 || phase_q == PH_HUNT2) |-> !esc_q)
    else $error("escape flag set while hunting");

  // payload phase always has bytes left to take
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (bcnt_q < flen_q))
    else $error("payload count reached frame length");

  // only payload words carry data
  a_status_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status != ST_PAYLOAD) |-> (out_q.payload_byte == '0))
    else $error("end status with nonzero payload byte");

  // a held result is not overwritten
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result lost");
`endif

endmodule
